>>> rtl/tilt_pkg.sv
// Shared types, register codes, constants and helper functions for the tilt filter.
// No dependencies; every other file but tilt_div refers to it by scoped names.
package tilt_pkg;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } sample_t;

  typedef struct packed {
    logic [16:0] pitch_angle;
    logic [16:0] roll_angle;
    logic [8:0]  rate_x;
    logic [8:0]  rate_y;
    logic [8:0]  rate_z;
  } tilt_t;

  // configuration register indexes
  localparam logic [1:0] CFG_FILTER_WEIGHT = 2'd0;
  localparam logic [1:0] CFG_TIME_STEP     = 2'd1;
  localparam logic [1:0] CFG_GYRO_DIVISOR  = 2'd2;

  localparam logic [16:0] WEIGHT_RESET    = 17'd55706;
  localparam logic [16:0] WEIGHT_ONE      = 17'd65536;
  localparam logic [15:0] TIME_STEP_RESET = 16'd655;
  localparam logic [15:0] DIVISOR_RESET   = 16'd131;

  localparam int DIV_STEPS = 16;
  localparam int MAC_LEN   = 6;

  localparam logic signed [25:0] DEG90_Q16  = 26'sd5898240;
  localparam logic signed [25:0] DEG180_Q16 = 26'sd11796480;

  typedef enum logic [2:0] {
    MAC_NONE,
    MAC_RT,     // rate * dt, accel angle rounding
    MAC_WP,     // w * (rate * dt)
    MAC_WO,     // w * old
    MAC_WA,     // (1 - w) * accel
    MAC_SUM,
    MAC_ROUND
  } mac_op_t;

  typedef struct packed {
    logic       load;
    logic       cordic_en;
    logic       div_en;
    logic [4:0] iter;
    mac_op_t    mac;
    logic       wrap_init;
    logic       wrap_step;
    logic       out_load;
  } cmd_t;

  // atan(2^-i) in degrees, Q16
  function automatic logic [21:0] atan_deg(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  // clamp to +-250 deg/s, negative codes offset by 500
  function automatic logic [8:0] rate_code(input logic signed [16:0] r);
    logic signed [16:0] c;
    c = r;
    if (c > 17'sd250) c = 17'sd250;
    if (c < -17'sd250) c = -17'sd250;
    if (c < 17'sd0) c = c + 17'sd500;
    return c[8:0];
  endfunction

endpackage

>>> rtl/tilt_cordic.sv
// One CORDIC vectoring lane: atan2(num, den) in degrees, Q16, one iteration a cycle while step_en is high.
// Depends on tilt_pkg for the angle table and angle constants.
module tilt_cordic (
  input  logic                clk,
  input  logic                init,
  input  logic                step_en,
  input  logic [4:0]          iter,
  input  logic signed [15:0]  num,
  input  logic signed [15:0]  den,
  output logic signed [25:0]  tilt
);

  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [25:0] z;
  logic               num_zero;
  logic               den_neg;
  logic signed [33:0] x0;
  logic signed [33:0] y0;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [25:0] step_angle;

  assign x0 = {{4{den[15]}}, den, 14'b0};
  assign y0 = {{4{num[15]}}, num, 14'b0};
  assign dx = x >>> iter;
  assign dy = y >>> iter;
  assign step_angle = signed'({4'b0, tilt_pkg::atan_deg(iter)});

  always_ff @(posedge clk) begin
    if (init) begin
      num_zero <= (num == 16'sd0);
      den_neg  <= den[15];
      if (den[15]) begin
        // left half plane: mirror and carry +-180
        x <= -x0;
        y <= -y0;
        z <= num[15] ? -tilt_pkg::DEG180_Q16 : tilt_pkg::DEG180_Q16;
      end else begin
        x <= x0;
        y <= y0;
        z <= 26'sd0;
      end
    end else if (step_en) begin
      if (!y[33]) begin
        x <= x + dy;
        y <= y - dx;
        z <= z + step_angle;
      end else begin
        x <= x - dy;
        y <= y + dx;
        z <= z - step_angle;
      end
    end
  end

  // zero numerator: exactly 0, or 180 when den is negative
  assign tilt = num_zero ? (den_neg ? tilt_pkg::DEG180_Q16 : 26'sd0) : z;

endmodule

>>> rtl/tilt_div.sv
// One restoring divider lane: signed gyro word over divisor, truncated toward zero.
// Does not depend on tilt_pkg; one quotient bit a cycle while step_en is high.
module tilt_div (
  input  logic               clk,
  input  logic               init,
  input  logic               step_en,
  input  logic signed [15:0] raw,
  input  logic [15:0]        divisor,
  output logic signed [16:0] rate
);

  logic        neg;
  logic [15:0] quo;
  logic [15:0] rem;
  logic [15:0] dvs;
  logic [16:0] trial;

  assign trial = {rem, quo[15]};

  always_ff @(posedge clk) begin
    if (init) begin
      neg <= raw[15];
      quo <= raw[15] ? 16'(-raw) : raw;
      rem <= 16'd0;
      dvs <= (divisor == 16'd0) ? 16'd1 : divisor;
    end else if (step_en) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= 16'(trial - {1'b0, dvs});
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= trial[15:0];
        quo <= {quo[14:0], 1'b0};
      end
    end
  end

  assign rate = neg ? -signed'({1'b0, quo}) : signed'({1'b0, quo});

endmodule

>>> rtl/tilt_ctrl.sv
// Sequencer for the tilt filter: run, multiply-accumulate, wrap and output phases.
// Depends on tilt_pkg for the command struct and phase lengths.
module tilt_ctrl #(
  parameter int CORDIC_STEPS        = 16,
  parameter int ANGLE_FRACTION_BITS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            sample_valid,
  output logic            sample_stall,
  output logic            tilt_valid,
  input  logic            tilt_stall,
  output tilt_pkg::cmd_t  cmd
);

  localparam int RUN_LEN    = (CORDIC_STEPS > tilt_pkg::DIV_STEPS) ? CORDIC_STEPS
                                                                  : tilt_pkg::DIV_STEPS;
  localparam int WRAP_STEPS = 16 - ANGLE_FRACTION_BITS;

  typedef enum logic [2:0] {S_IDLE, S_RUN, S_MAC, S_WRAP, S_OUT} state_t;

  state_t     state;
  logic [4:0] cnt;
  logic       can_load;

  assign can_load     = !tilt_valid || !tilt_stall;
  assign sample_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= 5'd0;
      tilt_valid <= 1'b0;
    end else begin
      // new result loads, or a stalled beat stays up
      tilt_valid <= ((state == S_OUT) && can_load) || (tilt_valid && tilt_stall);
      case (state)
        S_IDLE: begin
          cnt <= 5'd0;
          if (sample_valid) state <= S_RUN;
        end
        S_RUN: begin
          if (cnt == 5'(RUN_LEN - 1)) begin
            cnt   <= 5'd0;
            state <= S_MAC;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_MAC: begin
          if (cnt == 5'(tilt_pkg::MAC_LEN - 1)) begin
            cnt   <= 5'd0;
            state <= S_WRAP;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_WRAP: begin
          if (cnt == 5'(WRAP_STEPS)) begin
            cnt   <= 5'd0;
            state <= S_OUT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_OUT: begin
          if (can_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.mac       = tilt_pkg::MAC_NONE;
    cmd.iter      = cnt;
    cmd.load      = (state == S_IDLE) && sample_valid;
    cmd.cordic_en = (state == S_RUN) && (cnt < 5'(CORDIC_STEPS));
    cmd.div_en    = (state == S_RUN) && (cnt < 5'(tilt_pkg::DIV_STEPS));
    cmd.wrap_init = (state == S_WRAP) && (cnt == 5'd0);
    cmd.wrap_step = (state == S_WRAP) && (cnt != 5'd0);
    cmd.out_load  = (state == S_OUT) && can_load;
    if (state == S_MAC) begin
      case (cnt)
        5'd0:    cmd.mac = tilt_pkg::MAC_RT;
        5'd1:    cmd.mac = tilt_pkg::MAC_WP;
        5'd2:    cmd.mac = tilt_pkg::MAC_WO;
        5'd3:    cmd.mac = tilt_pkg::MAC_WA;
        5'd4:    cmd.mac = tilt_pkg::MAC_SUM;
        5'd5:    cmd.mac = tilt_pkg::MAC_ROUND;
        default: cmd.mac = tilt_pkg::MAC_NONE;
      endcase
    end
  end

endmodule

>>> rtl/tilt_datapath.sv
// Datapath: config registers, CORDIC and divider lanes, filter MAC, angle wrap, result reg.
// Depends on tilt_pkg, tilt_cordic and tilt_div.
module tilt_datapath #(
  parameter int ANGLE_FRACTION_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  tilt_pkg::cmd_t    cmd,
  input  tilt_pkg::sample_t sample,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [16:0]       cfg_data,
  output tilt_pkg::tilt_t   tilt
);

  localparam int F          = ANGLE_FRACTION_BITS;
  localparam int RS         = 16 - F;
  localparam int WRAP_STEPS = 16 - F;
  localparam logic signed [26:0] ACC_HALF = 27'sd1 <<< (RS - 1);
  localparam logic signed [63:0] MAC_HALF = 64'sd2147483648;
  localparam logic [23:0] MOD_FULL = 24'(360 << F);
  localparam logic [23:0] MOD_TOP  = 24'(360 << (F + WRAP_STEPS - 1));

  logic [16:0] filter_weight;
  logic [15:0] time_step;
  logic [15:0] gyro_divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_weight <= tilt_pkg::WEIGHT_RESET;
      time_step     <= tilt_pkg::TIME_STEP_RESET;
      gyro_divisor  <= tilt_pkg::DIVISOR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        tilt_pkg::CFG_FILTER_WEIGHT: filter_weight <= cfg_data;
        tilt_pkg::CFG_TIME_STEP:     time_step     <= cfg_data[15:0];
        tilt_pkg::CFG_GYRO_DIVISOR:  gyro_divisor  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic signed [16:0] rate_x;
  logic signed [16:0] rate_y;
  logic signed [16:0] rate_z;
  logic signed [25:0] tilt_q16 [2];

  // lane 0 is pitch, lane 1 is roll
  tilt_cordic u_cordic_pitch (
    .clk(clk), .init(cmd.load), .step_en(cmd.cordic_en), .iter(cmd.iter),
    .num(sample.accel_x), .den(sample.accel_z), .tilt(tilt_q16[0])
  );
  tilt_cordic u_cordic_roll (
    .clk(clk), .init(cmd.load), .step_en(cmd.cordic_en), .iter(cmd.iter),
    .num(sample.accel_y), .den(sample.accel_z), .tilt(tilt_q16[1])
  );

  tilt_div u_div_x (
    .clk(clk), .init(cmd.load), .step_en(cmd.div_en),
    .raw(sample.gyro_x), .divisor(gyro_divisor), .rate(rate_x)
  );
  tilt_div u_div_y (
    .clk(clk), .init(cmd.load), .step_en(cmd.div_en),
    .raw(sample.gyro_y), .divisor(gyro_divisor), .rate(rate_y)
  );
  tilt_div u_div_z (
    .clk(clk), .init(cmd.load), .step_en(cmd.div_en),
    .raw(sample.gyro_z), .divisor(gyro_divisor), .rate(rate_z)
  );

  logic [16:0]        w_sat;
  logic signed [17:0] w_s;
  logic signed [17:0] wc_s;
  logic signed [16:0] rate_yn;
  logic signed [16:0] lane_rate [2];

  assign w_sat        = (filter_weight > tilt_pkg::WEIGHT_ONE) ? tilt_pkg::WEIGHT_ONE
                                                               : filter_weight;
  assign w_s          = signed'({1'b0, w_sat});
  assign wc_s         = signed'({1'b0, 17'(tilt_pkg::WEIGHT_ONE - w_sat)});
  assign rate_yn      = -rate_y;
  assign lane_rate[0] = rate_yn;
  assign lane_rate[1] = rate_x;

  logic signed [26:0] accel_q   [2];
  logic signed [26:0] accel_rnd [2];
  logic signed [52:0] prod      [2];
  logic signed [52:0] prod_next [2];
  logic signed [17:0] mul_a     [2];
  logic signed [34:0] mul_b     [2];
  logic signed [63:0] acc       [2];
  logic signed [31:0] acc_rnd   [2];
  logic signed [23:0] mem       [2];
  logic signed [23:0] mem_next  [2];
  logic [23:0]        rem       [2];
  logic [23:0]        wrapped   [2];
  logic               wneg      [2];
  logic [23:0]        modv;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      logic signed [26:0] v;
      logic signed [63:0] r64;
      v = 27'(tilt_q16[k]) + 27'(tilt_pkg::DEG90_Q16);
      accel_rnd[k] = (v + ACC_HALF - signed'({26'b0, v[26]})) >>> RS;
      case (cmd.mac)
        tilt_pkg::MAC_RT: begin
          mul_a[k] = 18'(lane_rate[k]);
          mul_b[k] = signed'({19'b0, time_step});
        end
        tilt_pkg::MAC_WP: begin
          mul_a[k] = w_s;
          mul_b[k] = prod[k][34:0];
        end
        tilt_pkg::MAC_WO: begin
          mul_a[k] = w_s;
          mul_b[k] = 35'(mem[k]);
        end
        tilt_pkg::MAC_WA: begin
          mul_a[k] = wc_s;
          mul_b[k] = 35'(accel_q[k]);
        end
        default: begin
          mul_a[k] = 18'sd0;
          mul_b[k] = 35'sd0;
        end
      endcase
      prod_next[k] = mul_a[k] * mul_b[k];
      r64 = (acc[k] + MAC_HALF - signed'({63'b0, acc[k][63]})) >>> 32;
      acc_rnd[k] = r64[31:0];
      if (acc_rnd[k] > 32'sd8388607)       mem_next[k] = 24'sd8388607;
      else if (acc_rnd[k] < -32'sd8388608) mem_next[k] = -24'sd8388608;
      else                                 mem_next[k] = acc_rnd[k][23:0];
      wrapped[k] = (wneg[k] && rem[k] != 24'd0) ? (MOD_FULL - rem[k]) : rem[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem[0] <= 24'sd0;
      mem[1] <= 24'sd0;
    end else begin
      for (int k = 0; k < 2; k++) begin
        if (cmd.mac == tilt_pkg::MAC_ROUND) mem[k] <= mem_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      if (cmd.mac != tilt_pkg::MAC_NONE && cmd.mac != tilt_pkg::MAC_ROUND) begin
        prod[k] <= prod_next[k];
      end
      case (cmd.mac)
        tilt_pkg::MAC_RT:  accel_q[k] <= accel_rnd[k];
        tilt_pkg::MAC_WO:  acc[k] <= 64'(prod[k]) <<< F;
        tilt_pkg::MAC_WA,
        tilt_pkg::MAC_SUM: acc[k] <= acc[k] + (64'(prod[k]) <<< 16);
        default: ;
      endcase
      if (cmd.wrap_init) begin
        wneg[k] <= mem[k][23];
        rem[k]  <= mem[k][23] ? 24'(-mem[k]) : mem[k];
      end else if (cmd.wrap_step && rem[k] >= modv) begin
        rem[k] <= rem[k] - modv;
      end
    end
    if (cmd.wrap_init)      modv <= MOD_TOP;
    else if (cmd.wrap_step) modv <= modv >> 1;
    if (cmd.out_load) begin
      tilt.pitch_angle <= wrapped[0][16:0];
      tilt.roll_angle  <= wrapped[1][16:0];
      tilt.rate_x      <= tilt_pkg::rate_code(rate_x);
      tilt.rate_y      <= tilt_pkg::rate_code(rate_yn);
      tilt.rate_z      <= tilt_pkg::rate_code(rate_z);
    end
  end

endmodule

>>> rtl/imu_complementary_tilt_filter_core.sv
// Top level of the complementary tilt filter: controller plus datapath.
// Depends on tilt_pkg, tilt_ctrl and tilt_datapath.
//
// Use:
//   sample channel (sample_valid / sample_stall / sample) takes one beat of raw
//   accel and gyro words. tilt channel (tilt_valid / tilt_stall / tilt) gives one
//   beat with pitch, roll (1/2^ANGLE_FRACTION_BITS degree, wrapped to [0,360))
//   and three integer rate codes. cfg_write / cfg_index / cfg_data write the
//   weight, time step and gyro divisor; write only while the block is idle.
//
// Timing: one sample at a time. A sample passes through the CORDIC and divider
//   lanes, then the filter multiply-accumulate and the serial angle wrap, and
//   then its result is loaded. sample_stall drops again when the result is
//   loaded, so the next sample is taken only after that.
//   The run phase holds the CORDIC loop, one iteration per cycle, and the
//   divider lanes.
//
// Reset (rst, synchronous): the config registers return to their defaults, both kept
//   angles clear to zero, no result pending.
// Stall: a finished result waits in the output register; the next sample is
//   still taken and worked on, and its result loads once the previous beat left.
module imu_complementary_tilt_filter_core #(
  parameter int CORDIC_STEPS        = 16,
  parameter int ANGLE_FRACTION_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  tilt_pkg::sample_t sample,
  output logic              tilt_valid,
  input  logic              tilt_stall,
  output tilt_pkg::tilt_t   tilt,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [16:0]       cfg_data
);

  tilt_pkg::cmd_t cmd;

  tilt_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .tilt_valid(tilt_valid),
    .tilt_stall(tilt_stall),
    .cmd(cmd)
  );

  tilt_datapath #(
    .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .sample(sample),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .tilt(tilt)
  );

endmodule
